/* hdl/pngccf_pkg.sv */
// Shared types, constants and CRC function for the PNG critical chunk filter.
package pngccf_pkg;

	// Most result items one input beat can produce
	localparam int unsigned SlotCount = 8;
	localparam int unsigned SlotIdxW  = $clog2(SlotCount);
	localparam int unsigned SlotCntW  = $clog2(SlotCount + 2);

	localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
	localparam logic [31:0] CrcPreset = 32'hFFFF_FFFF;

	localparam logic [31:0] TypeIhdr = 32'h4948_4452;
	localparam logic [31:0] TypePlte = 32'h504C_5445;
	localparam logic [31:0] TypeIdat = 32'h4944_4154;
	localparam logic [31:0] TypeIend = 32'h4945_4E44;

	localparam logic [31:0] SigBytes = 32'd8;
	localparam logic [31:0] FldBytes = 32'd4;

	typedef enum logic [4:0] {
		PH_SIG  = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_TYPE = 5'b00100,
		PH_DATA = 5'b01000,
		PH_CRC  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
	} feed_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       chunk_done;
		logic       crc_error;
		logic       chunk_kept;
		logic       last;
	} result_t;

	// Results caused by one input beat: bytes in slot order, then an optional done
	typedef struct packed {
		logic [SlotCount-1:0][7:0] bytes;
		logic [SlotCntW-1:0]       nbyte;
		logic                      done;
		logic                      err;
		logic                      kept;
	} burst_t;

	// Reflected CRC-32 update over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic is_critical(input logic [31:0] t);
		return (t == TypeIhdr) || (t == TypePlte) || (t == TypeIdat) || (t == TypeIend);
	endfunction

endpackage

/* hdl/pngccf_parser.sv */
// Chunk parser: stream state, CRC update and result burst for each input beat.
module pngccf_parser
	import pngccf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   take,
	input  feed_t  feed,
	output burst_t burst
);

	phase_t      phase_q, ph, n_ph;
	logic [31:0] cnt_q, cnt, n_cnt, cnt_inc;
	logic [31:0] len_q, len, n_len;
	logic [31:0] type_q, typ, n_typ;
	logic [31:0] crc_q, crc, n_crc;
	logic [31:0] scrc_q, scrc, n_scrc;
	logic        keep_q, keep, n_keep;
	logic        crc_bad;
	logic [7:0]  b;

	assign b = feed.in_byte;

	// Work out next state and the results of this beat
	always_comb begin
		ph   = phase_q;
		cnt  = cnt_q;
		len  = len_q;
		typ  = type_q;
		crc  = crc_q;
		scrc = scrc_q;
		keep = keep_q;
		if (feed.file_start) begin
			ph   = PH_SIG;
			cnt  = '0;
			len  = '0;
			typ  = '0;
			crc  = CrcPreset;
			scrc = '0;
			keep = 1'b0;
		end
		// Recover from a corrupt phase code as the start of a length field
		if (!(ph inside {PH_SIG, PH_LEN, PH_TYPE, PH_DATA, PH_CRC})) begin
			ph  = PH_LEN;
			cnt = '0;
		end
		cnt_inc = cnt + 32'd1;
		n_ph    = ph;
		n_cnt   = cnt;
		n_len   = len;
		n_typ   = typ;
		n_crc   = crc;
		n_scrc  = scrc;
		n_keep  = keep;
		crc_bad = 1'b0;
		burst   = '0;
		case (ph)
			PH_SIG: begin
				burst.bytes[0] = b;
				burst.nbyte    = SlotCntW'(1);
				n_cnt          = cnt_inc;
				if (cnt_inc >= SigBytes) begin
					n_ph  = PH_LEN;
					n_cnt = '0;
				end
			end
			PH_LEN: begin
				n_len = {((cnt == '0) ? 24'd0 : len[23:0]), b};
				n_cnt = cnt_inc;
				if (cnt_inc >= FldBytes) begin
					n_ph   = PH_TYPE;
					n_cnt  = '0;
					n_typ  = '0;
					n_scrc = '0;
					n_crc  = CrcPreset;
				end
			end
			PH_TYPE: begin
				n_typ = {typ[23:0], b};
				n_crc = crc_byte(crc, b);
				n_cnt = cnt_inc;
				if (cnt_inc >= FldBytes) begin
					n_keep = is_critical(n_typ);
					if (n_keep) begin
						burst.bytes[0] = len[31:24];
						burst.bytes[1] = len[23:16];
						burst.bytes[2] = len[15:8];
						burst.bytes[3] = len[7:0];
						burst.bytes[4] = n_typ[31:24];
						burst.bytes[5] = n_typ[23:16];
						burst.bytes[6] = n_typ[15:8];
						burst.bytes[7] = n_typ[7:0];
						burst.nbyte    = SlotCntW'(8);
					end
					n_cnt = '0;
					n_ph  = (len == '0) ? PH_CRC : PH_DATA;
				end
			end
			PH_DATA: begin
				n_crc = crc_byte(crc, b);
				if (keep) begin
					burst.bytes[0] = b;
					burst.nbyte    = SlotCntW'(1);
				end
				n_cnt = cnt_inc;
				if (cnt_inc == len) begin
					n_cnt = '0;
					n_ph  = PH_CRC;
				end
			end
			PH_CRC: begin
				n_scrc = {scrc[23:0], b};
				n_cnt  = cnt_inc;
				if (cnt_inc >= FldBytes) begin
					crc_bad = (~crc) != n_scrc;
					if (keep && !crc_bad) begin
						burst.bytes[0] = n_scrc[31:24];
						burst.bytes[1] = n_scrc[23:16];
						burst.bytes[2] = n_scrc[15:8];
						burst.bytes[3] = n_scrc[7:0];
						burst.nbyte    = SlotCntW'(4);
					end
					burst.done = 1'b1;
					burst.err  = crc_bad;
					burst.kept = keep;
					n_ph       = PH_LEN;
					n_cnt      = '0;
				end
			end
			default: begin
				n_ph = PH_LEN;
			end
		endcase
	end

	// Advance parser state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			cnt_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			crc_q   <= CrcPreset;
			scrc_q  <= '0;
			keep_q  <= 1'b0;
		end else if (take) begin
			phase_q <= n_ph;
			cnt_q   <= n_cnt;
			len_q   <= n_len;
			type_q  <= n_typ;
			crc_q   <= n_crc;
			scrc_q  <= n_scrc;
			keep_q  <= n_keep;
		end
	end

endmodule

/* hdl/pngccf_serializer.sv */
// Result register: holds a beat's burst, hands out one result per unstalled cycle.
module pngccf_serializer
	import pngccf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  burst_t  burst,
	output logic    can_load,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic [SlotCount-1:0][7:0] bytes_q;
	logic [SlotCntW-1:0]       nbyte_q;
	logic                      err_q;
	logic                      kept_q;
	logic [SlotCntW-1:0]       pos_q;
	logic [SlotCntW-1:0]       rem_q;
	logic                      is_byte;
	logic                      take;

	assign result_valid = rem_q != '0;
	assign take         = result_valid && !result_stall;
	assign can_load     = (rem_q == '0) || ((rem_q == SlotCntW'(1)) && !result_stall);
	assign is_byte      = pos_q < nbyte_q;

	// Present the current result of the held burst
	always_comb begin
		result.out_byte   = is_byte ? bytes_q[pos_q[SlotIdxW-1:0]] : 8'd0;
		result.byte_valid = is_byte;
		result.chunk_done = !is_byte;
		result.crc_error  = !is_byte && err_q;
		result.chunk_kept = !is_byte && kept_q;
		result.last       = rem_q == SlotCntW'(1);
	end

	// Payload of the held burst
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
			nbyte_q <= burst.nbyte;
			err_q   <= burst.err;
			kept_q  <= burst.kept;
		end
	end

	// Load a new burst or step to the next result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			rem_q <= '0;
		end else if (load) begin
			pos_q <= '0;
			rem_q <= burst.nbyte + SlotCntW'(burst.done);
		end else if (take) begin
			pos_q <= pos_q + SlotCntW'(1);
			rem_q <= rem_q - SlotCntW'(1);
		end
	end

endmodule

/* hdl/png_critical_chunk_filter_top.sv */
// PNG critical chunk filter top level: parser plus result register.
//
// The feed channel takes one file byte per beat, with file_start marking the
// first signature byte of a new file. The result channel returns the filtered
// stream: signature bytes, the header, data and matching CRC of IHDR, PLTE,
// IDAT and IEND chunks, and one done beat per chunk with its CRC status. A
// feed beat is parsed and its CRC-32 update done in the cycle it is taken; its
// first result appears in the cycle after. Each beat makes zero to eight
// results and, while the receiver does not stall, the register hands them out
// one per cycle and the feed takes one byte per cycle while each byte gives at
// most one result; a beat that gives more holds the feed back until its last
// result leaves (eight after a kept chunk type, five after a kept chunk with a
// good CRC). A new beat is taken in the same cycle as the last result of the
// previous one leaves. Reset returns the parser to the signature phase and
// empties the result register. While the receiver stalls, the current result
// holds and the feed stalls once the register cannot take another burst.
module png_critical_chunk_filter_top
	import pngccf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    feed_valid,
	output logic    feed_stall,
	input  feed_t   feed,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	burst_t burst;
	logic   can_load;
	logic   take;

	assign feed_stall = !can_load;
	assign take       = feed_valid && can_load;

	pngccf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.feed   (feed),
		.burst  (burst)
	);

	pngccf_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take),
		.burst        (burst),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	// The feed is held back only while results are still pending
	a_stall_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		feed_stall |-> result_valid)
		else $error("feed stalled with no pending result");

	// A done beat closes the burst of its input byte
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.chunk_done |-> result.last)
		else $error("done result not last of its burst");

	// Every result is either a data byte or a done beat
	a_byte_or_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.byte_valid != result.chunk_done)
		else $error("result is neither byte nor done");
`endif

endmodule

/* tb/png_critical_chunk_filter_top_tb.sv */
// Self-checking testbench for the PNG critical chunk filter: byte predictor and result scoreboard.
module png_critical_chunk_filter_top_tb
	import pngccf_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] PngSignature = 64'h8950_4E47_0D0A_1A0A;
	localparam logic [31:0] TypeText     = 32'h7445_5874;
	localparam int          CycleLimit   = 400000;
	localparam int          RandomBytes  = 250;

	logic    clk;
	logic    arst_n;
	logic    feed_valid;
	logic    feed_stall;
	feed_t   feed;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// Expected filtered stream, oldest first
	result_t expected_stream[$];
	result_t head_result;

	// Predictor copy of the parser state
	phase_t      pred_phase;
	logic [31:0] pred_count;
	logic [31:0] pred_len;
	logic [31:0] pred_type;
	logic [31:0] pred_crc;
	logic [31:0] pred_stored;
	logic        pred_keep;

	int fail_count;
	int fed_bytes;
	int cycle_count;
	int feed_idle_max;
	int result_idle_max;

	png_critical_chunk_filter_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (feed_valid),
		.feed_stall   (feed_stall),
		.feed         (feed),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Free-running clock, 8 ns period
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_stream.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Reflected CRC-32, one data bit folded in per step
	function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] d);
		logic [31:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ d[i])
				r = {1'b0, r[31:1]} ^ CrcPoly;
			else
				r = {1'b0, r[31:1]};
		end
		return r;
	endfunction

	function automatic int idle_draw(input int ceiling);
		return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, ceiling)) : 0;
	endfunction

	function automatic logic [31:0] critical_type(input int idx);
		case (idx)
			0: return TypeIhdr;
			1: return TypePlte;
			2: return TypeIdat;
			default: return TypeIend;
		endcase
	endfunction

	function automatic result_t byte_result(input logic [7:0] b);
		result_t r;
		r = '0;
		r.out_byte   = b;
		r.byte_valid = 1'b1;
		return r;
	endfunction

	function automatic void clear_parser();
		pred_phase  = PH_SIG;
		pred_count  = '0;
		pred_len    = '0;
		pred_type   = '0;
		pred_crc    = CrcPreset;
		pred_stored = '0;
		pred_keep   = 1'b0;
	endfunction

	// Work out the results one accepted feed beat causes
	function automatic void predict_filter(input feed_t f);
		int      prior_size;
		logic    err;
		result_t done_beat;
		prior_size = expected_stream.size();
		if (f.file_start)
			clear_parser();
		case (pred_phase)
			PH_SIG: begin
				expected_stream.push_back(byte_result(f.in_byte));
				pred_count++;
				if (pred_count >= 8) begin
					pred_phase = PH_LEN;
					pred_count = '0;
				end
			end
			PH_LEN: begin
				if (pred_count == 0)
					pred_len = '0;
				pred_len = {pred_len[23:0], f.in_byte};
				pred_count++;
				if (pred_count >= 4) begin
					pred_phase  = PH_TYPE;
					pred_count  = '0;
					pred_type   = '0;
					pred_stored = '0;
					pred_crc    = CrcPreset;
				end
			end
			PH_TYPE: begin
				pred_type = {pred_type[23:0], f.in_byte};
				pred_crc  = crc32_update(pred_crc, f.in_byte);
				pred_count++;
				if (pred_count >= 4) begin
					pred_keep = (pred_type == TypeIhdr) || (pred_type == TypePlte) ||
						(pred_type == TypeIdat) || (pred_type == TypeIend);
					// Release held-back length and type together
					if (pred_keep) begin
						for (int k = 3; k >= 0; k--)
							expected_stream.push_back(byte_result(pred_len[8*k +: 8]));
						for (int k = 3; k >= 0; k--)
							expected_stream.push_back(byte_result(pred_type[8*k +: 8]));
					end
					pred_count = '0;
					pred_phase = (pred_len == 0) ? PH_CRC : PH_DATA;
				end
			end
			PH_DATA: begin
				pred_crc = crc32_update(pred_crc, f.in_byte);
				if (pred_keep)
					expected_stream.push_back(byte_result(f.in_byte));
				pred_count++;
				if (pred_count == pred_len) begin
					pred_count = '0;
					pred_phase = PH_CRC;
				end
			end
			PH_CRC: begin
				pred_stored = {pred_stored[23:0], f.in_byte};
				pred_count++;
				if (pred_count >= 4) begin
					err = ((pred_crc ^ CrcPreset) != pred_stored);
					if (pred_keep && !err) begin
						for (int k = 3; k >= 0; k--)
							expected_stream.push_back(byte_result(pred_stored[8*k +: 8]));
					end
					done_beat            = '0;
					done_beat.chunk_done = 1'b1;
					done_beat.crc_error  = err;
					done_beat.chunk_kept = pred_keep;
					expected_stream.push_back(done_beat);
					pred_phase = PH_LEN;
					pred_count = '0;
				end
			end
			default: begin
				pred_phase = PH_LEN;
				pred_count = '0;
			end
		endcase
		if (expected_stream.size() > prior_size)
			expected_stream[expected_stream.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string field, input logic [7:0] want,
		input logic [7:0] got);
		$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
		fail_count++;
	endtask

	// Check every accepted result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_stream.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %p", $time, result);
				fail_count++;
			end else begin
				head_result = expected_stream.pop_front();
				if (result.out_byte !== head_result.out_byte)
					report_mismatch("out_byte", head_result.out_byte, result.out_byte);
				if (result.byte_valid !== head_result.byte_valid)
					report_mismatch("byte_valid", 8'(head_result.byte_valid),
						8'(result.byte_valid));
				if (result.chunk_done !== head_result.chunk_done)
					report_mismatch("chunk_done", 8'(head_result.chunk_done),
						8'(result.chunk_done));
				if (result.crc_error !== head_result.crc_error)
					report_mismatch("crc_error", 8'(head_result.crc_error),
						8'(result.crc_error));
				if (result.chunk_kept !== head_result.chunk_kept)
					report_mismatch("chunk_kept", 8'(head_result.chunk_kept),
						8'(result.chunk_kept));
				if (result.last !== head_result.last)
					report_mismatch("last", 8'(head_result.last), 8'(result.last));
			end
		end
	end

	// Receiver: hold stall for a drawn number of cycles before each beat
	initial begin
		int gap;
		result_stall <= 1'b0;
		wait (arst_n);
		forever begin
			gap = idle_draw(result_idle_max);
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	// Send one file byte as a feed beat and predict its results
	task automatic send_byte(input logic [7:0] b, input bit start);
		int    gap;
		feed_t beat;
		gap = idle_draw(feed_idle_max);
		beat.in_byte    = b;
		beat.file_start = start;
		if (gap > 0) begin
			feed_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed_valid <= 1'b1;
		feed       <= beat;
		@(posedge clk);
		while (feed_stall) @(posedge clk);
		predict_filter(beat);
		fed_bytes++;
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int k = 3; k >= 0; k--)
			send_byte(w[8*k +: 8], 1'b0);
	endtask

	task automatic send_signature(input bit genuine);
		for (int i = 0; i < 8; i++)
			send_byte(genuine ? PngSignature[8*(7-i) +: 8] : 8'($urandom_range(0, 255)), i == 0);
	endtask

	// Send length, type, body and, if the body is complete, the CRC
	task automatic send_chunk(input logic [31:0] len, input logic [31:0] ctype,
		input logic [7:0] body[$], input bit bad_crc);
		logic [31:0] acc;
		acc = CrcPreset;
		for (int k = 3; k >= 0; k--)
			acc = crc32_update(acc, ctype[8*k +: 8]);
		foreach (body[i])
			acc = crc32_update(acc, body[i]);
		acc = acc ^ CrcPreset;
		if (bad_crc)
			acc = acc ^ (32'h1 << $urandom_range(0, 31));
		send_word(len);
		send_word(ctype);
		foreach (body[i])
			send_byte(body[i], 1'b0);
		if (body.size() == len)
			send_word(acc);
	endtask

	// Hold the feed until every expected result has left
	task automatic wait_drain();
		feed_valid <= 1'b0;
		@(posedge clk);
		while (expected_stream.size() != 0) @(posedge clk);
	endtask

	task automatic test_signature();
		feed_idle_max   = 0;
		result_idle_max = 0;
		send_signature(1'b1);
	endtask

	task automatic test_kept_chunk();
		logic [7:0] body[$];
		feed_idle_max   = 11;
		result_idle_max = 0;
		body.push_back(8'h00);
		body.push_back(8'hFF);
		send_chunk(32'd2, TypeIhdr, body, 1'b0);
	endtask

	task automatic test_crc_mismatch();
		logic [7:0] body[$];
		feed_idle_max   = 0;
		result_idle_max = 11;
		body.push_back(8'hA5);
		send_chunk(32'd1, TypePlte, body, 1'b1);
	endtask

	task automatic test_dropped_chunk();
		logic [7:0] body[$];
		feed_idle_max   = 11;
		result_idle_max = 11;
		body.push_back(8'h5A);
		send_chunk(32'd1, TypeText, body, 1'b0);
	endtask

	// Zero-length IEND, then parsing goes on into a further chunk
	task automatic test_iend_and_beyond();
		logic [7:0] body[$];
		feed_idle_max   = 0;
		result_idle_max = 0;
		send_chunk(32'd0, TypeIend, body, 1'b0);
		body.push_back(8'h3C);
		send_chunk(32'd1, TypeIdat, body, 1'b0);
	endtask

	// Maximum length field cut short by a new file
	task automatic test_huge_length_restart();
		logic [7:0] body[$];
		feed_idle_max   = 11;
		result_idle_max = 0;
		body.push_back(8'hFF);
		body.push_back(8'h00);
		send_chunk(32'hFFFF_FFFF, TypeIdat, body, 1'b0);
		send_signature(1'b1);
		body.delete();
		send_chunk(32'd0, TypeIdat, body, 1'b1);
	endtask

	task automatic test_drain_pause();
		wait_drain();
	endtask

	task automatic send_random_file();
		int          nchunks;
		int          len;
		logic [31:0] ctype;
		logic [7:0]  body[$];
		feed_idle_max   = $urandom_range(0, 1) ? 11 : 0;
		result_idle_max = $urandom_range(0, 1) ? 11 : 0;
		send_signature($urandom_range(0, 5) != 0);
		nchunks = $urandom_range(1, 5);
		repeat (nchunks) begin
			body.delete();
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: ctype = critical_type($urandom_range(0, 3));
				6, 7:             ctype = $urandom();
				8:                ctype = critical_type($urandom_range(0, 3)) ^
				                          (32'h1 << $urandom_range(0, 31));
				default: begin
					// Noise: broken chunk, the next file restarts the parser
					repeat ($urandom_range(1, 10))
						send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
					return;
				end
			endcase
			for (int i = 0; i < len; i++)
				body.push_back(8'($urandom_range(0, 255)));
			send_chunk(len, ctype, body, $urandom_range(0, 4) == 0);
		end
		if ($urandom_range(0, 4) == 0)
			wait_drain();
	endtask

	task automatic test_random_files();
		int start_count;
		start_count = fed_bytes;
		while (fed_bytes - start_count < RandomBytes)
			send_random_file();
	endtask

	// Reset, run the tests in turn, drain and report
	initial begin
		arst_n          <= 1'b0;
		feed_valid      <= 1'b0;
		feed            <= '0;
		fed_bytes       = 0;
		feed_idle_max   = 0;
		result_idle_max = 0;
		clear_parser();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_signature();
		test_kept_chunk();
		test_crc_mismatch();
		test_dropped_chunk();
		test_iend_and_beyond();
		test_huge_length_restart();
		test_drain_pause();
		test_random_files();

		feed_valid <= 1'b0;
		@(posedge clk);
		while (expected_stream.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
